/* rtl/iaf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_pkg: shared types and constants of the integer-to-ASCII formatter
// Holds the job control record, the back-end state type, character codes
// and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package iaf_pkg;

  localparam int PAD_W    = 6;   // width of the minimum digit count
  localparam int RADIX_W  = 5;   // holds bases 2 to 16
  localparam int CHAR_W   = 7;
  localparam int DIGIT_W  = 4;
  localparam int STEP_BITS = 8;  // dividend bits retired per divider cycle

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CH_B     = 7'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_O     = 7'h6f;  // 'o'
  localparam logic [CHAR_W-1:0] CH_D     = 7'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;  // no prefix

  localparam logic [7:0] RADIX_MIN = 8'd2;
  localparam logic [7:0] RADIX_MAX = 8'd16;

  // Control part of one classified request
  typedef struct packed {
    logic               neg;
    logic [RADIX_W-1:0] radix;
    logic [CHAR_W-1:0]  pchar;
    logic [PAD_W-1:0]   min_digits;
  } job_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_LOAD,
    B_SIGN,
    B_PFX0,
    B_PFXC,
    B_PAD,
    B_DIGIT
  } back_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

/* rtl/iaf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_front: request classifier
// Checks the base, splits the value into sign and magnitude, picks the
// prefix letter and saturates the padding count, then pushes the job.
// ----------------------------------------------------------------------------
module iaf_front #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_PAD    = 60
) (
  input  logic                      start,
  input  logic                      full_i,
  input  logic [VALUE_BITS-1:0]     value_i,
  input  logic [7:0]                radix_i,
  input  logic                      show_prefix_i,
  input  logic [iaf_pkg::PAD_W-1:0] min_digits_i,
  output logic                      push_o,
  output logic [VALUE_BITS-1:0]     mag_o,
  output iaf_pkg::job_ctl_t         ctl_o
);

  logic radix_ok;
  logic neg;

  assign radix_ok = (radix_i >= iaf_pkg::RADIX_MIN) && (radix_i <= iaf_pkg::RADIX_MAX);
  assign neg      = value_i[VALUE_BITS-1];

  // Drop requests with a bad base: accepted, but nothing is queued
  assign push_o = start && !full_i && radix_ok;
  assign mag_o  = neg ? (~value_i + VALUE_BITS'(1)) : value_i;

  always_comb begin
    ctl_o.neg   = neg;
    ctl_o.radix = radix_i[iaf_pkg::RADIX_W-1:0];
    ctl_o.pchar = iaf_pkg::CH_NONE;
    if (show_prefix_i) begin
      case (radix_i)
        8'd2:    ctl_o.pchar = iaf_pkg::CH_B;
        8'd8:    ctl_o.pchar = iaf_pkg::CH_O;
        8'd10:   ctl_o.pchar = iaf_pkg::CH_D;
        8'd16:   ctl_o.pchar = iaf_pkg::CH_X;
        default: ctl_o.pchar = iaf_pkg::CH_NONE;
      endcase
    end
    ctl_o.min_digits = (min_digits_i > iaf_pkg::PAD_W'(MAX_PAD)) ?
                       iaf_pkg::PAD_W'(MAX_PAD) : min_digits_i;
  end

endmodule

/* rtl/iaf_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_fifo: two-entry job queue
// Decouples the classifier from the converter so each can stall on its own.
// ----------------------------------------------------------------------------
module iaf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/iaf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_back: digit converter and character sequencer
// Divides the magnitude by the base eight bits a cycle, stores the digits,
// then emits sign, prefix, padding and digits one character a cycle.
// ----------------------------------------------------------------------------
module iaf_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  logic [VALUE_BITS-1:0]      mag_i,
  input  iaf_pkg::job_ctl_t          ctl_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic [iaf_pkg::CHAR_W-1:0] character_o,
  output logic                       last_o
);

  localparam int STEP    = iaf_pkg::STEP_BITS;
  localparam int MAG_W   = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int CHUNKS  = MAG_W / STEP;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DEPTH   = VALUE_BITS;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int NDIG_W  = $clog2(DEPTH + 1);
  localparam int DW      = iaf_pkg::DIGIT_W;
  localparam int CW      = iaf_pkg::CHAR_W;
  localparam int PW      = iaf_pkg::PAD_W;

  iaf_pkg::back_state_e state_q, state_d;
  iaf_pkg::job_ctl_t    ctl_q;

  logic [MAG_W-1:0]   div_q, div_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [CHUNK_W-1:0] chunk_q;
  logic [NDIG_W-1:0]  ndig_q;
  logic [IDX_W-1:0]   didx_q;
  logic [PW-1:0]      pad_q, pad_calc;
  logic [DW-1:0]      dmem [DEPTH];
  logic [DW-1:0]      rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               last_chunk;
  logic               quot_zero;
  logic               has_pfx;

  logic               strobe_d, last_d;
  logic [CW-1:0]      char_d;

  assign last_chunk = (chunk_q == CHUNK_W'(CHUNKS - 1));
  assign quot_zero  = (div_d == '0);
  assign has_pfx    = (ctl_q.pchar != iaf_pkg::CH_NONE);
  assign pad_calc   = ({1'b0, ctl_q.min_digits} > (PW + 1)'(ndig_q)) ?
                      PW'(ctl_q.min_digits - PW'(ndig_q)) : '0;

  // Restoring division, eight quotient bits a cycle; remainder stays below base
  always_comb begin
    logic [DW:0]      t;
    logic [DW-1:0]    r;
    logic [STEP-1:0]  qb;
    logic [STEP-1:0]  top;
    r   = rem_q;
    qb  = '0;
    top = div_q[MAG_W-1 -: STEP];
    for (int i = STEP - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= (DW + 1)'(ctl_q.radix)) begin
        t     = t - (DW + 1)'(ctl_q.radix);
        qb[i] = 1'b1;
      end
      r = t[DW-1:0];
    end
    rem_d = r;
    div_d = (div_q << STEP) | MAG_W'(qb);
  end

  // Read one digit ahead of the character that shows it
  always_comb begin
    if (state_q == iaf_pkg::B_DIGIT) begin
      rd_addr = (didx_q == '0) ? '0 : didx_q - IDX_W'(1);
    end else begin
      rd_addr = (ndig_q == '0) ? '0 : IDX_W'(ndig_q - NDIG_W'(1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iaf_pkg::B_IDLE: begin
        if (!empty_i) state_d = iaf_pkg::B_DIV;
      end
      iaf_pkg::B_DIV: begin
        if (last_chunk && quot_zero) state_d = iaf_pkg::B_LOAD;
      end
      iaf_pkg::B_LOAD: begin
        if (ctl_q.neg)           state_d = iaf_pkg::B_SIGN;
        else if (has_pfx)        state_d = iaf_pkg::B_PFX0;
        else if (pad_calc != '0) state_d = iaf_pkg::B_PAD;
        else                     state_d = iaf_pkg::B_DIGIT;
      end
      iaf_pkg::B_SIGN: begin
        if (has_pfx)          state_d = iaf_pkg::B_PFX0;
        else if (pad_q != '0) state_d = iaf_pkg::B_PAD;
        else                  state_d = iaf_pkg::B_DIGIT;
      end
      iaf_pkg::B_PFX0: begin
        state_d = iaf_pkg::B_PFXC;
      end
      iaf_pkg::B_PFXC: begin
        state_d = (pad_q != '0) ? iaf_pkg::B_PAD : iaf_pkg::B_DIGIT;
      end
      iaf_pkg::B_PAD: begin
        if (pad_q == PW'(1)) state_d = iaf_pkg::B_DIGIT;
      end
      iaf_pkg::B_DIGIT: begin
        if (didx_q == '0) state_d = iaf_pkg::B_IDLE;
      end
      default: state_d = iaf_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o    = 1'b0;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    char_d   = iaf_pkg::CH_ZERO;
    case (state_q)
      iaf_pkg::B_IDLE:  pop_o = !empty_i;
      iaf_pkg::B_SIGN: begin
        strobe_d = 1'b1;
        char_d   = iaf_pkg::CH_MINUS;
      end
      iaf_pkg::B_PFX0,
      iaf_pkg::B_PAD: begin
        strobe_d = 1'b1;
        char_d   = iaf_pkg::CH_ZERO;
      end
      iaf_pkg::B_PFXC: begin
        strobe_d = 1'b1;
        char_d   = ctl_q.pchar;
      end
      iaf_pkg::B_DIGIT: begin
        strobe_d = 1'b1;
        char_d   = iaf_pkg::digit_char(rd_q);
        last_d   = (didx_q == '0);
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= iaf_pkg::B_IDLE;
      strobe_o <= 1'b0;
      ndig_q   <= '0;
      chunk_q  <= '0;
    end else begin
      state_q  <= state_d;
      strobe_o <= strobe_d;
      case (state_q)
        iaf_pkg::B_IDLE: begin
          ndig_q  <= '0;
          chunk_q <= '0;
        end
        iaf_pkg::B_DIV: begin
          if (last_chunk) begin
            chunk_q <= '0;
            ndig_q  <= ndig_q + NDIG_W'(1);
          end else begin
            chunk_q <= chunk_q + CHUNK_W'(1);
          end
        end
        default: begin
          chunk_q <= '0;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    character_o <= char_d;
    last_o      <= last_d;
    rd_q        <= dmem[rd_addr];
    case (state_q)
      iaf_pkg::B_IDLE: begin
        ctl_q <= ctl_i;
        div_q <= MAG_W'(mag_i);
        rem_q <= '0;
      end
      iaf_pkg::B_DIV: begin
        if (last_chunk) begin
          dmem[ndig_q[IDX_W-1:0]] <= rem_d;
          rem_q <= '0;
        end else begin
          rem_q <= rem_d;
        end
        div_q <= div_d;
      end
      iaf_pkg::B_LOAD: begin
        pad_q  <= pad_calc;
        didx_q <= IDX_W'(ndig_q - NDIG_W'(1));
      end
      iaf_pkg::B_PAD: begin
        pad_q <= pad_q - PW'(1);
      end
      iaf_pkg::B_DIGIT: begin
        didx_q <= didx_q - IDX_W'(1);
      end
      default: begin
        pad_q <= pad_q;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> (state_q == iaf_pkg::B_IDLE))
    else $error("last character not at end of job");
  a_digit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iaf_pkg::B_DIGIT) |-> (NDIG_W'(didx_q) < ndig_q))
    else $error("digit index beyond stored digits");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iaf_pkg::B_DIV) |-> (ndig_q < NDIG_W'(DEPTH)))
    else $error("digit buffer overflow");
`endif

endmodule

/* rtl/integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: signed integer to ASCII text
// Flow: start pushes the job into the queue; the converter pops it, divides
//   out each digit in turn, then emits the text from a registered output.
// Throughput: one character per cycle while emitting; the converter takes a
//   new request from the queue only when the text of the last one is done.
// The receiver cannot stall: each character shows for one cycle with strobe_o.
// Reset clears the queue and sequencer; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_PAD    = 60
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [VALUE_BITS-1:0]      value_i,
  input  logic [7:0]                 radix_i,
  input  logic                       show_prefix_i,
  input  logic [iaf_pkg::PAD_W-1:0]  min_digits_i,
  output logic                       strobe_o,
  output logic [iaf_pkg::CHAR_W-1:0] character_o,
  output logic                       last_o
);

  localparam int JOB_W = VALUE_BITS + $bits(iaf_pkg::job_ctl_t);

  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  logic [VALUE_BITS-1:0] mag_in, mag_out;
  iaf_pkg::job_ctl_t     ctl_in, ctl_out;
  logic [JOB_W-1:0]      job_out;

  // Hold off new requests only while the job queue is full
  assign busy = full;

  // Classify the request; bad bases are accepted and dropped here
  iaf_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_PAD    (MAX_PAD)
  ) u_front (
    .start         (start),
    .full_i        (full),
    .value_i       (value_i),
    .radix_i       (radix_i),
    .show_prefix_i (show_prefix_i),
    .min_digits_i  (min_digits_i),
    .push_o        (push),
    .mag_o         (mag_in),
    .ctl_o         (ctl_in)
  );

  // Queue classified jobs between front and back
  iaf_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({mag_in, ctl_in}),
    .pop_i   (pop),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign mag_out = job_out[JOB_W-1 -: VALUE_BITS];
  assign ctl_out = job_out[$bits(iaf_pkg::job_ctl_t)-1:0];

  // Convert to digits and stream the characters out
  iaf_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .mag_i       (mag_out),
    .ctl_i       (ctl_out),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

/* tb/tb_integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top: self-checking bench for the formatter
// Drives format requests through the start/busy handshake and rebuilds the
// expected text of each accepted request in the bench. Each strobed character
// is checked against that text in order. Directed corner cases come first,
// then random requests, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_top;

  localparam int VALUE_BITS = 32;
  localparam int MAX_PAD    = 60;
  localparam int CHAR_W     = iaf_pkg::CHAR_W;
  localparam int PAD_W      = iaf_pkg::PAD_W;

  // Bases that carry a prefix, and the valid base range
  localparam logic [7:0] BASE_LO  = 8'd2;
  localparam logic [7:0] BASE_HI  = 8'd16;
  localparam logic [7:0] BASE_BIN = 8'd2;
  localparam logic [7:0] BASE_OCT = 8'd8;
  localparam logic [7:0] BASE_DEC = 8'd10;
  localparam logic [7:0] BASE_HEX = 8'd16;

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_B     = 7'h62;
  localparam logic [CHAR_W-1:0] ASCII_O     = 7'h6f;
  localparam logic [CHAR_W-1:0] ASCII_D     = 7'h64;
  localparam logic [CHAR_W-1:0] ASCII_X     = 7'h78;
  localparam logic [CHAR_W-1:0] NO_PREFIX   = 7'h00;

  localparam byte DIGIT_GLYPH [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                       "8", "9", "a", "b", "c", "d", "e", "f"};

  localparam int RANDOM_REQS = 235;   // random requests with a valid base
  localparam int CALM_TAIL   = 40;    // last requests are sent without gaps
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake or strobe
  localparam int DRAIN_CYCLES = 250;  // quiet time after the last character

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [7:0]            radix;
    logic                  show_prefix;
    logic [PAD_W-1:0]      min_digits;
  } format_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Request ports, held at known values from time zero
  logic                  start       = 1'b0;
  logic [VALUE_BITS-1:0] value       = '0;
  logic [7:0]            radix       = '0;
  logic                  show_prefix = 1'b0;
  logic [PAD_W-1:0]      min_digits  = '0;

  logic              busy;
  logic              strobe_o;
  logic [CHAR_W-1:0] character_o;
  logic              last_o;

  format_req_t pending_reqs [$];   // requests not yet put on the ports
  text_char_t  expected_text [$];  // characters still owed by the block
  format_req_t presented;          // request currently on the ports

  int error_count = 0;
  int idle_cycles = 0;
  int gap_left    = 0;
  bit hold_one    = 1'b0;
  bit wait_idle   = 1'b0;

  integer_to_ascii_formatter_top #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_PAD   (MAX_PAD)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value),
    .radix_i      (radix),
    .show_prefix_i(show_prefix),
    .min_digits_i (min_digits),
    .strobe_o     (strobe_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Build the text of one request and append it to the expected characters.
  // Bases outside 2..16 owe nothing.
  function automatic void format_expected(input format_req_t req);
    logic [VALUE_BITS-1:0] mag;
    logic [CHAR_W-1:0]     digits [$];
    logic [CHAR_W-1:0]     text [$];
    logic [CHAR_W-1:0]     pfx;
    text_char_t            tc;
    int                    pad;
    int                    n;
    if (req.radix < BASE_LO || req.radix > BASE_HI) begin
      return;
    end
    pad = (req.min_digits > MAX_PAD) ? MAX_PAD : int'(req.min_digits);
    // Two's complement negate is exact for the most negative value as well
    mag = req.value[VALUE_BITS-1] ? (~req.value + 1'b1) : req.value;
    do begin
      digits.push_front(CHAR_W'(DIGIT_GLYPH[mag % req.radix]));
      mag = mag / req.radix;
    end while (mag != 0);

    if (req.value[VALUE_BITS-1]) begin
      text.push_back(ASCII_MINUS);
    end
    case (req.radix)
      BASE_BIN: pfx = ASCII_B;
      BASE_OCT: pfx = ASCII_O;
      BASE_DEC: pfx = ASCII_D;
      BASE_HEX: pfx = ASCII_X;
      default:  pfx = NO_PREFIX;
    endcase
    // The sign goes ahead of the prefix; zero padding comes after it
    if (req.show_prefix && pfx != NO_PREFIX) begin
      text.push_back(ASCII_ZERO);
      text.push_back(pfx);
    end
    for (n = digits.size(); n < pad; n++) begin
      text.push_back(ASCII_ZERO);
    end
    foreach (digits[k]) begin
      text.push_back(digits[k]);
    end
    foreach (text[k]) begin
      tc.character = text[k];
      tc.last      = (k == text.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  task automatic queue_req(input logic [VALUE_BITS-1:0] v, input logic [7:0] r,
                           input logic p, input logic [PAD_W-1:0] m);
    format_req_t req;
    req.value       = v;
    req.radix       = r;
    req.show_prefix = p;
    req.min_digits  = m;
    pending_reqs.push_back(req);
  endtask

  // Mix of full-range values, small magnitudes, extremes and powers of two
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, 20);
      1:       v = -$urandom_range(1, 20);
      2: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          3:       v = 32'hffff_ffff;
          default: v = 32'h8000_0001;
        endcase
      end
      3:       v = 32'd1 << $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Fill the request list: directed corners, then random requests
  initial begin
    int valid_reqs;
    logic [7:0] r;
    logic [PAD_W-1:0] m;

    // Zero, with and without padding
    queue_req(32'd0, 8'd10, 1'b0, 6'd0);
    queue_req(32'd0, 8'd16, 1'b1, 6'd5);
    // Extremes of the signed range in bases 2, 10 and 16, and one octal value
    queue_req(32'h7fff_ffff, 8'd2, 1'b1, 6'd0);
    queue_req(32'h8000_0000, 8'd2, 1'b1, 6'd0);
    queue_req(32'h8000_0000, 8'd10, 1'b1, 6'd0);
    queue_req(32'h8000_0000, 8'd16, 1'b1, 6'd0);
    queue_req(32'hffff_ffff, 8'd16, 1'b1, 6'd0);
    queue_req(32'd123, 8'd8, 1'b1, 6'd0);
    // Negative value with prefix and zero padding
    queue_req(-32'sd5, 8'd10, 1'b1, 6'd4);
    // Bases that have no prefix, mostly with the prefix flag set
    queue_req(32'd255, 8'd3, 1'b1, 6'd0);
    queue_req(32'd100, 8'd7, 1'b1, 6'd2);
    queue_req(32'd99, 8'd9, 1'b1, 6'd0);
    queue_req(32'd4660, 8'd15, 1'b0, 6'd0);
    queue_req(-32'sd2147483647, 8'd5, 1'b1, 6'd0);
    // Bases out of range: no text at all
    queue_req(32'd0, 8'd0, 1'b1, 6'd3);
    queue_req(32'd42, 8'd1, 1'b0, 6'd0);
    queue_req(32'd42, 8'd17, 1'b1, 6'd0);
    queue_req(-32'sd42, 8'd255, 1'b1, 6'd63);
    // Padding at and beyond the saturation point; longest possible text
    queue_req(32'h8000_0000, 8'd10, 1'b1, 6'd60);
    queue_req(32'hffff_ffff, 8'd2, 1'b1, 6'd63);
    queue_req(32'd12345, 8'd10, 1'b0, 6'd61);
    queue_req(32'h0000_cafe, 8'd16, 1'b1, 6'd62);
    queue_req(32'h7fff_ffff, 8'd16, 1'b0, 6'd3);
    queue_req(32'd1, 8'd2, 1'b0, 6'd0);
    queue_req(32'h00ab_cdef, 8'd16, 1'b1, 6'd8);

    valid_reqs = 0;
    while (valid_reqs < RANDOM_REQS) begin
      if ($urandom_range(0, 9) == 0) begin
        r = 8'($urandom_range(0, 255));
      end else begin
        r = 8'($urandom_range(BASE_LO, BASE_HI));
      end
      case ($urandom_range(0, 9))
        0:       m = PAD_W'($urandom_range(0, 63));
        1, 2:    m = PAD_W'($urandom_range(0, 40));
        default: m = PAD_W'($urandom_range(0, 12));
      endcase
      queue_req(pick_value(), r, 1'($urandom_range(0, 1)), m);
      if (r >= BASE_LO && r <= BASE_HI) begin
        valid_reqs++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request handed over, then every character seen
    while (pending_reqs.size() != 0 || start) begin
      @(posedge clk_i);
    end
    while (expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    // Leave room for stray characters after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Request driver. Hold start until the handshake completes, then either
  // present the next request at once, idle for a short burst, or wait for
  // busy to drop and idle a burst after that. No gaps near the end.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        format_expected(presented);
        if (pending_reqs.size() > CALM_TAIL) begin
          case ($urandom_range(0, 3))
            0: gap_left = $urandom_range(1, 6);
            1: begin
              // Let busy settle before trusting it
              hold_one  = 1'b1;
              wait_idle = 1'b1;
              gap_left  = $urandom_range(1, 6);
            end
            default: gap_left = 0;
          endcase
        end
      end

      if (start && busy) begin
        // hold the pending request on the ports
      end else if (hold_one) begin
        hold_one = 1'b0;
        start <= 1'b0;
      end else if (wait_idle && busy) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        wait_idle = 1'b0;
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        wait_idle   = 1'b0;
        presented   = pending_reqs.pop_front();
        start       <= 1'b1;
        value       <= presented.value;
        radix       <= presented.radix;
        show_prefix <= presented.show_prefix;
        min_digits  <= presented.min_digits;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Character monitor: every strobe must match the oldest owed character
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && strobe_o) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character: character=%h last=%b", character_o, last_o);
        error_count++;
      end else begin
        exp_c = expected_text.pop_front();
        if (character_o !== exp_c.character) begin
          $error("character: expected %h, got %h", exp_c.character, character_o);
          error_count++;
        end
        if (last_o !== exp_c.last) begin
          $error("last: expected %b, got %b", exp_c.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up when neither a request nor a character moves
  always @(posedge clk_i) begin
    if ((start && !busy && rst_ni) || strobe_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
